@@ hdl/ptw_pkg.sv @@
`timescale 1ns / 1ps
package ptw_pkg;

  // Pool geometry
  localparam int POOL_TABLES_DEF   = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int SLICE_W           = 9;
  localparam int PN_W              = 40;  // physical page number, bits 51:12
  localparam int STEP_W            = 5;

  // Entry bit positions
  localparam int E_PRESENT  = 0;
  localparam int E_WRITABLE = 1;
  localparam int E_USER     = 2;
  localparam int E_HUGE     = 7;

  // Walk level holding the PD entry (huge page check)
  localparam logic [1:0] LVL_PD = 2'd2;

  // Request codes
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_MAP    = 2'd1;
  localparam logic [1:0] REQ_UNMAP  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_NONE = 3'd1;
  localparam logic [2:0] ST_HUGE = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_BAD  = 3'd4;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD_OUT,
    OP_READ,
    OP_LATCH_ENT,
    OP_ALLOC,
    OP_WIDEN,
    OP_SET_T,
    OP_INC_LVL,
    OP_SET_VALUE,
    OP_CLEAR_LEAF,
    OP_WRITE_LEAF
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_SKIP,
    C_HUGE,
    C_PRESENT,
    C_NO_CREATE,
    C_FULL,
    C_NOT_LAST,
    C_IS_MAP,
    C_IS_UNMAP,
    C_NOT_PRESENT,
    C_NOT_PU,
    C_BAD,
    C_OUT_BUSY
  } cond_t;

  // Microprogram step addresses
  localparam logic [STEP_W-1:0] S_DONE   = 5'd0;
  localparam logic [STEP_W-1:0] S_IDLE   = 5'd1;
  localparam logic [STEP_W-1:0] S_DISP   = 5'd2;
  localparam logic [STEP_W-1:0] S_RD     = 5'd3;
  localparam logic [STEP_W-1:0] S_EVAL   = 5'd4;
  localparam logic [STEP_W-1:0] S_HUGE   = 5'd5;
  localparam logic [STEP_W-1:0] S_PRES   = 5'd6;
  localparam logic [STEP_W-1:0] S_NOCR   = 5'd7;
  localparam logic [STEP_W-1:0] S_FULL   = 5'd8;
  localparam logic [STEP_W-1:0] S_ALLOC  = 5'd9;
  localparam logic [STEP_W-1:0] S_WIDEN  = 5'd10;
  localparam logic [STEP_W-1:0] S_CHECK  = 5'd11;
  localparam logic [STEP_W-1:0] S_NEXT   = 5'd12;
  localparam logic [STEP_W-1:0] S_LEAF   = 5'd13;
  localparam logic [STEP_W-1:0] S_LRD    = 5'd14;
  localparam logic [STEP_W-1:0] S_LEVAL  = 5'd15;
  localparam logic [STEP_W-1:0] S_LKIND  = 5'd16;
  localparam logic [STEP_W-1:0] S_LRES   = 5'd17;
  localparam logic [STEP_W-1:0] S_LOK    = 5'd18;
  localparam logic [STEP_W-1:0] S_UNMAP  = 5'd19;
  localparam logic [STEP_W-1:0] S_UCLR   = 5'd20;
  localparam logic [STEP_W-1:0] S_MAPW   = 5'd21;

  // One control word
  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              set_st;
    logic [2:0]        st;
  } uword_t;

  // Condition inputs from the datapath
  typedef struct packed {
    logic no_item;
    logic skip;
    logic huge;
    logic present;
    logic no_create;
    logic full;
    logic not_last;
    logic is_map;
    logic is_unmap;
    logic not_pu;
    logic bad;
    logic out_busy;
  } flags_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    op_t        op;
    logic       taken;
    logic       set_st;
    logic [2:0] st;
  } ctl_t;

  function automatic uword_t uw(input op_t op, input cond_t cond,
                                input logic [STEP_W-1:0] target,
                                input logic set_st, input logic [2:0] st);
    uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.set_st = set_st;
    w.st     = st;
    return w;
  endfunction

  // Microprogram; a taken jump falls through to the next step otherwise
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      S_DONE:  w = uw(OP_LOAD_OUT,   C_OUT_BUSY,    S_DONE,  1'b0, ST_OK);
      S_IDLE:  w = uw(OP_ACCEPT,     C_NO_ITEM,     S_IDLE,  1'b0, ST_OK);
      S_DISP:  w = uw(OP_NOP,        C_SKIP,        S_DONE,  1'b1, ST_NONE);
      S_RD:    w = uw(OP_READ,       C_NEVER,       S_DONE,  1'b0, ST_OK);
      S_EVAL:  w = uw(OP_LATCH_ENT,  C_NEVER,       S_DONE,  1'b0, ST_OK);
      S_HUGE:  w = uw(OP_NOP,        C_HUGE,        S_DONE,  1'b1, ST_HUGE);
      S_PRES:  w = uw(OP_NOP,        C_PRESENT,     S_WIDEN, 1'b0, ST_OK);
      S_NOCR:  w = uw(OP_NOP,        C_NO_CREATE,   S_DONE,  1'b1, ST_NONE);
      S_FULL:  w = uw(OP_NOP,        C_FULL,        S_DONE,  1'b1, ST_FULL);
      S_ALLOC: w = uw(OP_ALLOC,      C_ALWAYS,      S_NEXT,  1'b0, ST_OK);
      S_WIDEN: w = uw(OP_WIDEN,      C_NEVER,       S_DONE,  1'b0, ST_OK);
      S_CHECK: w = uw(OP_SET_T,      C_BAD,         S_DONE,  1'b1, ST_BAD);
      S_NEXT:  w = uw(OP_INC_LVL,    C_NOT_LAST,    S_RD,    1'b0, ST_OK);
      S_LEAF:  w = uw(OP_NOP,        C_IS_MAP,      S_MAPW,  1'b0, ST_OK);
      S_LRD:   w = uw(OP_READ,       C_NEVER,       S_DONE,  1'b0, ST_OK);
      S_LEVAL: w = uw(OP_LATCH_ENT,  C_NEVER,       S_DONE,  1'b0, ST_OK);
      S_LKIND: w = uw(OP_NOP,        C_IS_UNMAP,    S_UNMAP, 1'b0, ST_OK);
      S_LRES:  w = uw(OP_SET_VALUE,  C_NOT_PRESENT, S_DONE,  1'b1, ST_NONE);
      S_LOK:   w = uw(OP_NOP,        C_ALWAYS,      S_DONE,  1'b1, ST_OK);
      S_UNMAP: w = uw(OP_NOP,        C_NOT_PU,      S_DONE,  1'b1, ST_NONE);
      S_UCLR:  w = uw(OP_CLEAR_LEAF, C_ALWAYS,      S_DONE,  1'b1, ST_OK);
      S_MAPW:  w = uw(OP_WRITE_LEAF, C_ALWAYS,      S_DONE,  1'b1, ST_OK);
      default: w = uw(OP_NOP,        C_ALWAYS,      S_IDLE,  1'b0, ST_OK);
    endcase
    return w;
  endfunction

endpackage

@@ hdl/ptw_ram.sv @@
`timescale 1ns / 1ps
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ptw_sequencer.sv @@
`timescale 1ns / 1ps
module ptw_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  ptw_pkg::flags_t flags,
  output ptw_pkg::ctl_t   ctl
);

  localparam int SW = ptw_pkg::STEP_W;

  logic [SW-1:0]    upc;
  logic [SW-1:0]    upc_next;
  ptw_pkg::uword_t  word;
  logic             cond_true;

  // Control word fetch, condition select, next step
  always_comb begin
    word = ptw_pkg::ucode(upc);
    case (word.cond)
      ptw_pkg::C_NEVER:       cond_true = 1'b0;
      ptw_pkg::C_ALWAYS:      cond_true = 1'b1;
      ptw_pkg::C_NO_ITEM:     cond_true = flags.no_item;
      ptw_pkg::C_SKIP:        cond_true = flags.skip;
      ptw_pkg::C_HUGE:        cond_true = flags.huge;
      ptw_pkg::C_PRESENT:     cond_true = flags.present;
      ptw_pkg::C_NO_CREATE:   cond_true = flags.no_create;
      ptw_pkg::C_FULL:        cond_true = flags.full;
      ptw_pkg::C_NOT_LAST:    cond_true = flags.not_last;
      ptw_pkg::C_IS_MAP:      cond_true = flags.is_map;
      ptw_pkg::C_IS_UNMAP:    cond_true = flags.is_unmap;
      ptw_pkg::C_NOT_PRESENT: cond_true = !flags.present;
      ptw_pkg::C_NOT_PU:      cond_true = flags.not_pu;
      ptw_pkg::C_BAD:         cond_true = flags.bad;
      ptw_pkg::C_OUT_BUSY:    cond_true = flags.out_busy;
      default:                cond_true = 1'b0;
    endcase
    upc_next   = cond_true ? word.target : upc + SW'(1);
    ctl.op     = word.op;
    ctl.taken  = cond_true;
    ctl.set_st = word.set_st;
    ctl.st     = word.st;
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ptw_pkg::S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

@@ hdl/ptw_datapath.sv @@
`timescale 1ns / 1ps
module ptw_datapath #(
  parameter int POOL_TABLES = ptw_pkg::POOL_TABLES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [51:0]     cfg_wr_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      req_type,
  input  logic [47:0]     virt_addr,
  input  logic [51:0]     phys_addr,
  input  logic [11:0]     page_flags,
  input  logic [48:0]     range_end,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [63:0]     entry_value,
  output logic [2:0]      status,
  output logic            tlb_flush,
  input  ptw_pkg::ctl_t   ctl,
  output ptw_pkg::flags_t flags
);

  localparam int DEPTH = POOL_TABLES * ptw_pkg::ENTRIES_PER_TABLE;
  localparam int TW    = $clog2(POOL_TABLES);
  localparam int AW    = TW + ptw_pkg::SLICE_W;
  localparam int NW    = $clog2(POOL_TABLES + 1);
  localparam int PW    = ptw_pkg::PN_W;

  // Configuration and allocation state
  logic [PW-1:0] pool_pn;
  logic [NW-1:0] nft;
  logic          clearing;
  logic [AW-1:0] clr_cnt;

  // Request registers
  logic [1:0]    req;
  logic [35:0]   va_pn;
  logic [PW-1:0] pa_pn;
  logic [11:0]   flags_r;
  logic [48:0]   end_r;

  // Walk registers
  logic [1:0]    lvl;
  logic [TW-1:0] t;
  logic [63:0]   ent;
  logic [PW-1:0] off;
  logic [2:0]    st_r;
  logic [63:0]   value_r;
  logic          flush_r;

  // Memory port
  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;
  logic [AW-1:0] slot;
  logic [63:0]   rdata;

  logic [8:0]    slice;
  logic          user_req;
  logic [PW-1:0] alloc_pn;
  logic [63:0]   alloc_entry;
  logic [63:0]   leaf;
  logic [PW-1:0] off_next;
  logic [48:0]   page;
  logic          accept;
  logic          load_out;

  assign in_stall = clearing || (ctl.op != ptw_pkg::OP_ACCEPT);
  assign accept   = in_valid && !in_stall;

  // Index slice for the current level; level 3 is the PT slot
  always_comb begin
    case (lvl)
      2'd0:    slice = va_pn[35:27];
      2'd1:    slice = va_pn[26:18];
      2'd2:    slice = va_pn[17:9];
      default: slice = va_pn[8:0];
    endcase
  end

  assign slot        = {t, slice};
  assign user_req    = (req == ptw_pkg::REQ_MAP) && flags_r[ptw_pkg::E_USER];
  assign alloc_pn    = pool_pn + PW'(nft);
  assign alloc_entry = {12'b0, alloc_pn, 9'b0, user_req, 2'b11};
  assign leaf        = {12'b0, pa_pn, flags_r | 12'h001};
  assign off_next    = ent[51:12] - pool_pn;
  assign page        = {1'b0, va_pn, 12'b0};

  // Write port: clearing pass, then microcode writes
  always_comb begin
    we    = 1'b0;
    waddr = slot;
    wdata = '0;
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_cnt;
    end else begin
      case (ctl.op)
        ptw_pkg::OP_ALLOC: begin
          we    = 1'b1;
          wdata = alloc_entry;
        end
        ptw_pkg::OP_WIDEN: begin
          we    = user_req;
          wdata = ent | (64'd1 << ptw_pkg::E_USER);
        end
        ptw_pkg::OP_CLEAR_LEAF: begin
          we    = 1'b1;
        end
        ptw_pkg::OP_WRITE_LEAF: begin
          we    = 1'b1;
          wdata = leaf;
        end
        default: begin
          we    = 1'b0;
        end
      endcase
    end
  end

  ptw_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (slot),
    .rdata (rdata)
  );

  // Conditions for the sequencer
  always_comb begin
    flags.no_item   = !in_valid || clearing;
    flags.skip      = (req != ptw_pkg::REQ_LOOKUP && req != ptw_pkg::REQ_MAP &&
                       req != ptw_pkg::REQ_UNMAP) ||
                      (req == ptw_pkg::REQ_UNMAP && !(page < end_r));
    flags.huge      = (lvl == ptw_pkg::LVL_PD) && ent[ptw_pkg::E_PRESENT] &&
                      ent[ptw_pkg::E_HUGE];
    flags.present   = ent[ptw_pkg::E_PRESENT];
    flags.no_create = req != ptw_pkg::REQ_MAP;
    flags.full      = nft >= NW'(POOL_TABLES);
    flags.not_last  = lvl != ptw_pkg::LVL_PD;
    flags.is_map    = req == ptw_pkg::REQ_MAP;
    flags.is_unmap  = req == ptw_pkg::REQ_UNMAP;
    flags.not_pu    = !(ent[ptw_pkg::E_PRESENT] && ent[ptw_pkg::E_USER]);
    flags.bad       = off >= PW'(POOL_TABLES);
    flags.out_busy  = out_valid && out_stall;
  end

  assign load_out = (ctl.op == ptw_pkg::OP_LOAD_OUT) && !(out_valid && out_stall);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_pn   <= '0;
      nft       <= NW'(1);
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pool_pn <= cfg_wr_data[51:12];
      end
      if (ctl.op == ptw_pkg::OP_ALLOC) begin
        nft <= nft + NW'(1);
      end
      if (clearing) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture and walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req     <= req_type;
      va_pn   <= virt_addr[47:12];
      pa_pn   <= phys_addr[51:12];
      flags_r <= page_flags;
      end_r   <= range_end;
      lvl     <= 2'd0;
      t       <= '0;
      value_r <= '0;
      flush_r <= 1'b0;
    end
    case (ctl.op)
      ptw_pkg::OP_LATCH_ENT: ent <= rdata;
      ptw_pkg::OP_ALLOC:     t <= nft[TW-1:0];
      ptw_pkg::OP_WIDEN:     off <= off_next;
      ptw_pkg::OP_SET_T:     t <= off[TW-1:0];
      ptw_pkg::OP_INC_LVL:   lvl <= lvl + 2'd1;
      ptw_pkg::OP_SET_VALUE: value_r <= ent;
      ptw_pkg::OP_CLEAR_LEAF: flush_r <= 1'b1;
      ptw_pkg::OP_WRITE_LEAF: begin
        value_r <= leaf;
        flush_r <= 1'b1;
      end
      default: begin
      end
    endcase
    if (ctl.taken && ctl.set_st) begin
      st_r <= ctl.st;
    end
    if (load_out) begin
      entry_value <= value_r;
      status      <= st_r;
      tlb_flush   <= flush_r;
    end
  end

endmodule

@@ hdl/x86_64_page_table_walker.sv @@
`timescale 1ns / 1ps
// Four-level page table walker over a private pool of 4 KiB tables held in
// one on-chip store of POOL_TABLES * 512 entries; pool table 0 is the root.
// Requests arrive on the in_* channel (valid/stall): lookup, map or unmap of
// one page. Each transfer gives exactly one result on the out_* channel.
// pool_base is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while the block is idle, which the block does not enforce. Work
// is run by a microprogram driving one table store with one write port and
// one registered read port; each table access is a read step and decision
// steps. One item is worked on at a time. A skipped unmap or unused code
// goes straight to the result. The next item is taken the cycle after the
// result is loaded into the output register.
// After reset the store is cleared one entry per cycle, POOL_TABLES * 512
// entries (32768 at the default size); in_stall stays high meanwhile.
// A result waits in the output register while out_stall is high; the
// walker can still accept and walk the next request, and holds before its
// own result until the register frees up.
module x86_64_page_table_walker #(
  parameter int POOL_TABLES = ptw_pkg::POOL_TABLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [51:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [47:0] virt_addr,
  input  logic [51:0] phys_addr,
  input  logic [11:0] page_flags,
  input  logic [48:0] range_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] entry_value,
  output logic [2:0]  status,
  output logic        tlb_flush
);

  ptw_pkg::ctl_t   ctl;
  ptw_pkg::flags_t flags;

  ptw_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  ptw_datapath #(
    .POOL_TABLES (POOL_TABLES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .virt_addr   (virt_addr),
    .phys_addr   (phys_addr),
    .page_flags  (page_flags),
    .range_end   (range_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .entry_value (entry_value),
    .status      (status),
    .tlb_flush   (tlb_flush),
    .ctl         (ctl),
    .flags       (flags)
  );

endmodule

@@ hdl/ptw_checker.sv @@
`timescale 1ns / 1ps
module ptw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] entry_value,
  input logic [2:0]  status,
  input logic        tlb_flush
);

  // Store clearing holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("request accepted during clearing pass");

  // One request at a time: no transfer in the cycle after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("back-to-back request transfer");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(entry_value) &&
                                  $stable(status) && $stable(tlb_flush)))
    else $error("stalled result changed");

  // A flush only comes with a successful map or unmap
  a_flush_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tlb_flush) |-> (status == ptw_pkg::ST_OK))
    else $error("flush with non-ok status");

  // Error results carry no entry and no flush
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ptw_pkg::ST_HUGE || status == ptw_pkg::ST_FULL ||
                   status == ptw_pkg::ST_BAD)) |-> (entry_value == 64'd0 && !tlb_flush))
    else $error("error result with entry or flush");

endmodule

bind x86_64_page_table_walker ptw_checker u_chk (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import ptw_pkg::*;

  localparam int POOL_TABLES = POOL_TABLES_DEF;
  localparam logic [1:0] REQ_SPARE = 2'd3;  // unused request code
  localparam logic [48:0] LIMIT_TOP = 49'h1_0000_0000_0000;
  localparam logic [51:0] BASE_TOP = 52'hF_FFFF_FFFF_F000;
  localparam int PLAN_ROWS = 25;
  localparam int LONG_HOLD = 300;

  // Frequently used walk prefixes (PML4, PDPT, PD index) so that tables get reused
  localparam int HOT_N = 6;
  localparam int HOT_L4 [HOT_N] = '{0, 0, 0, 511, 511, 3};
  localparam int HOT_L3 [HOT_N] = '{0, 0, 511, 511, 0, 5};
  localparam int HOT_L2 [HOT_N] = '{0, 1, 0, 511, 3, 8};

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] va;
    logic [51:0] pa;
    logic [11:0] flags;
    logic [48:0] limit;
  } page_req_t;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  status;
    logic        flush;
  } walk_result_t;

  typedef struct packed {
    bit           cfg;
    logic [51:0]  base;
    page_req_t    rq;
    bit           fixed;
    walk_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [51:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [47:0] virt_addr;
  logic [51:0] phys_addr;
  logic [11:0] page_flags;
  logic [48:0] range_end;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] entry_value;
  logic [2:0]  status;
  logic        tlb_flush;

  // Mirror of the walker state
  logic [63:0] mirror_entry [POOL_TABLES * ENTRIES_PER_TABLE];
  int unsigned mirror_next_table;
  logic [51:0] mirror_base;

  walk_result_t due_results [$];
  int unsigned  mismatches = 0;
  int unsigned  results_taken = 0;
  int unsigned  requests_sent = 0;
  int unsigned  base_writes = 0;
  int unsigned  flush_seen = 0;
  int unsigned  status_seen [5] = '{0, 0, 0, 0, 0};

  x86_64_page_table_walker #(.POOL_TABLES(POOL_TABLES)) i_dut (.*);

  always #5 clk = ~clk;

  function automatic logic [47:0] va_of(input int l4, input int l3, input int l2,
                                        input int l1, input logic [11:0] low);
    return {l4[8:0], l3[8:0], l2[8:0], l1[8:0], low};
  endfunction

  function automatic page_req_t make_req(input logic [1:0] kind, input logic [47:0] va,
                                         input logic [51:0] pa, input logic [11:0] flags,
                                         input logic [48:0] limit);
    page_req_t q;
    q.kind  = kind;
    q.va    = va;
    q.pa    = pa;
    q.flags = flags;
    q.limit = limit;
    return q;
  endfunction

  // Walk the three upper levels; creates tables and widens user bits on a map
  function automatic logic [2:0] walk_tables(input logic [47:0] va, input bit create,
                                             input bit user, output int unsigned slot);
    int unsigned t;
    int unsigned s;
    int unsigned lvl;
    logic [63:0] e;
    logic [39:0] pn_off;
    t = 0;
    slot = 0;
    for (lvl = 0; lvl < 3; lvl++) begin
      s = t * ENTRIES_PER_TABLE + va[(39 - 9 * lvl) +: 9];
      e = mirror_entry[s];
      if (lvl == LVL_PD && e[E_PRESENT] && e[E_HUGE])
        return ST_HUGE;
      if (!e[E_PRESENT]) begin
        if (!create)
          return ST_NONE;
        if (mirror_next_table >= POOL_TABLES)
          return ST_FULL;
        e = {12'b0, mirror_base[51:12] + 40'(mirror_next_table), 12'b0};
        e[E_PRESENT]  = 1'b1;
        e[E_WRITABLE] = 1'b1;
        e[E_USER]     = user;
        mirror_next_table++;
        mirror_entry[s] = e;
      end else if (user) begin
        e[E_USER] = 1'b1;
        mirror_entry[s] = e;
      end
      // table number is the page offset from the pool base, modulo 2^40 pages
      pn_off = e[51:12] - mirror_base[51:12];
      if (pn_off >= POOL_TABLES)
        return ST_BAD;
      t = 32'(pn_off);
    end
    slot = t * ENTRIES_PER_TABLE + va[20:12];
    return ST_OK;
  endfunction

  // Result of one request, updating the mirrored tables
  function automatic walk_result_t serve_request(input page_req_t rq);
    walk_result_t res;
    int unsigned slot;
    logic [47:0] page;
    res = '0;
    res.status = ST_NONE;
    case (rq.kind)
      REQ_LOOKUP: begin
        res.status = walk_tables(rq.va, 1'b0, 1'b0, slot);
        if (res.status == ST_OK) begin
          res.value = mirror_entry[slot];
          if (!res.value[E_PRESENT])
            res.status = ST_NONE;
        end
      end
      REQ_MAP: begin
        res.status = walk_tables(rq.va, 1'b1, rq.flags[E_USER], slot);
        if (res.status == ST_OK) begin
          res.value = {12'b0, rq.pa[51:12], rq.flags};
          res.value[E_PRESENT] = 1'b1;
          mirror_entry[slot] = res.value;
          res.flush = 1'b1;
        end
      end
      REQ_UNMAP: begin
        page = {rq.va[47:12], 12'b0};
        if ({1'b0, page} < rq.limit) begin
          res.status = walk_tables(page, 1'b0, 1'b0, slot);
          if (res.status == ST_OK) begin
            if (mirror_entry[slot][E_PRESENT] && mirror_entry[slot][E_USER]) begin
              mirror_entry[slot] = '0;
              res.flush = 1'b1;
            end else begin
              res.status = ST_NONE;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Directed stimulus; rows with fixed set carry their expected result
  function automatic plan_row_t plan_row(input int i);
    plan_row_t p;
    p = '0;
    case (i)
      0: begin p.cfg = 1'b1; p.base = '0; end
      1: begin
        p.rq = make_req(REQ_LOOKUP, '0, '0, '0, '0);
        p.fixed = 1'b1; p.want.status = ST_NONE;
      end
      2: begin
        p.rq = make_req(REQ_UNMAP, '0, '0, '0, '0);
        p.fixed = 1'b1; p.want.status = ST_NONE;
      end
      3: begin
        p.rq = make_req(REQ_SPARE, '1, '1, '1, LIMIT_TOP);
        p.fixed = 1'b1; p.want.status = ST_NONE;
      end
      // builds tables 1..3; the leaf points at what becomes table 3 after a base shift
      4: p.rq = make_req(REQ_MAP, va_of(3, 5, 7, 5, 12'hABC), 52'h1000, 12'h007, '0);
      5: p.rq = make_req(REQ_MAP, va_of(3, 5, 7, 7, 12'h000), '1, 12'h083, '0);
      6: p.rq = make_req(REQ_LOOKUP, va_of(3, 5, 7, 5, 12'hFFF), '0, '0, '0);
      7: p.rq = make_req(REQ_MAP, '1, 52'hA_5A5A_5A5A_5FFF, 12'hFFF, '0);
      8: p.rq = make_req(REQ_LOOKUP, va_of(511, 511, 511, 511, 12'h000), '0, '0, '0);
      9: begin
        p.rq = make_req(REQ_UNMAP, '1, '0, '0, LIMIT_TOP);
        p.fixed = 1'b1; p.want.status = ST_OK; p.want.flush = 1'b1;
      end
      10: begin
        p.rq = make_req(REQ_LOOKUP, '1, '0, '0, '0);
        p.fixed = 1'b1; p.want.status = ST_NONE;
      end
      // page equal to the range end is outside the range
      11: begin
        p.rq = make_req(REQ_UNMAP, va_of(3, 5, 7, 5, 12'h123), '0, '0,
                        {1'b0, va_of(3, 5, 7, 5, 12'h000)});
        p.fixed = 1'b1; p.want.status = ST_NONE;
      end
      12: p.rq = make_req(REQ_MAP, va_of(3, 5, 7, 9, 12'h000), 52'h1234_5000, 12'h003, '0);
      13: p.rq = make_req(REQ_UNMAP, va_of(3, 5, 7, 9, 12'h800), '0, '0, LIMIT_TOP);
      14: begin
        p.rq = make_req(REQ_LOOKUP, va_of(3, 6, 0, 0, 12'h000), '0, '0, '0);
        p.fixed = 1'b1; p.want.status = ST_NONE;
      end
      // shift the pool down two tables: the PT now serves as PDPT and PD
      15: begin p.cfg = 1'b1; p.base = 52'hF_FFFF_FFFF_E000; end
      16: begin
        p.rq = make_req(REQ_LOOKUP, va_of(3, 5, 7, 0, 12'h000), '0, '0, '0);
        p.fixed = 1'b1; p.want.status = ST_HUGE;
      end
      17: p.rq = make_req(REQ_MAP, va_of(3, 5, 7, 1, 12'h000), '0, 12'h004, '0);
      18: begin p.cfg = 1'b1; p.base = BASE_TOP; end
      19: p.rq = make_req(REQ_LOOKUP, va_of(3, 5, 7, 5, 12'h000), '0, '0, '0);
      20: begin p.cfg = 1'b1; p.base = 52'h0_0001_2345_6FFF; end
      21: begin
        p.rq = make_req(REQ_LOOKUP, va_of(3, 5, 7, 5, 12'h000), '0, '0, '0);
        p.fixed = 1'b1; p.want.status = ST_BAD;
      end
      22: p.rq = make_req(REQ_MAP, va_of(2, 0, 0, 0, 12'h000), 52'h7000, 12'h005, '0);
      23: begin p.cfg = 1'b1; p.base = '0; end
      default: p.rq = make_req(REQ_UNMAP, va_of(3, 5, 7, 5, 12'h000), '0, '0, LIMIT_TOP);
    endcase
    return p;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random request: mostly hot prefixes, some fresh regions and noise
  function automatic page_req_t random_req(input int fresh_pct);
    page_req_t q;
    int r;
    int h;
    int l1;
    logic [47:0] page;
    r = $urandom_range(0, 99);
    h = $urandom_range(0, HOT_N - 1);
    l1 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 15);
    q.va = va_of(HOT_L4[h], HOT_L3[h], HOT_L2[h], l1, 12'($urandom));
    q.pa = 52'({$urandom, $urandom});
    q.flags = 12'($urandom);
    if ($urandom_range(0, 9) < 7)
      q.flags[E_USER] = 1'b1;
    if (r < fresh_pct) begin
      q.kind = REQ_MAP;
      q.va = 48'({$urandom, $urandom});
    end else if (r < fresh_pct + 3) begin
      q.kind = REQ_LOOKUP;
      q.va = 48'({$urandom, $urandom});
    end else if (r < fresh_pct + 8) begin
      q.kind = REQ_SPARE;
    end else begin
      case ($urandom_range(0, 2))
        0: q.kind = REQ_MAP;
        1: q.kind = REQ_LOOKUP;
        default: q.kind = REQ_UNMAP;
      endcase
    end
    page = {q.va[47:12], 12'b0};
    case ($urandom_range(0, 9))
      0: q.limit = LIMIT_TOP;
      1: q.limit = '0;
      2: q.limit = {1'b0, page};
      3: q.limit = {1'b0, 48'({$urandom, $urandom})};
      default: begin
        q.limit = {1'b0, page} + 49'($urandom_range(1, 65536));
        if (q.limit > LIMIT_TOP)
          q.limit = LIMIT_TOP;
      end
    endcase
    return q;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one request at a falling edge; predict once the transfer happens
  task automatic offer(input page_req_t rq, input bit fixed, input walk_result_t want);
    walk_result_t got;
    in_valid   <= 1'b1;
    req_type   <= rq.kind;
    virt_addr  <= rq.va;
    phys_addr  <= rq.pa;
    page_flags <= rq.flags;
    range_end  <= rq.limit;
    do @(posedge clk); while (in_stall);
    got = serve_request(rq);
    due_results.push_back(fixed ? want : got);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // pool_base only changes with the walker drained
  task automatic set_pool_base(input logic [51:0] b);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mirror_base = b;
    base_writes++;
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    walk_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with no request outstanding", entry_value, '0);
      end else begin
        want = due_results.pop_front();
        if (entry_value !== want.value)
          report_mismatch("entry_value", entry_value, want.value);
        if (status !== want.status)
          report_mismatch("status", 64'(status), 64'(want.status));
        if (tlb_flush !== want.flush)
          report_mismatch("tlb_flush", 64'(tlb_flush), 64'(want.flush));
      end
      results_taken++;
      if (status < 5)
        status_seen[status]++;
      if (tlb_flush)
        flush_seen++;
    end
  end

  // Result side back-pressure, with calm stretches and long hold-offs
  initial begin : result_pace
    int unsigned cyc;
    int unsigned hold_left;
    int unsigned next_hold_at;
    out_stall = 1'b0;
    cyc = 0;
    hold_left = 0;
    next_hold_at = 150;
    forever begin
      @(negedge clk);
      cyc++;
      if (results_taken >= next_hold_at) begin
        // long hold-off: the walker fills up and stalls its input
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        next_hold_at += 450;
      end else if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
        if ((cyc % 600) >= 150 && $urandom_range(0, 3) == 0)
          hold_left = idle_len();
      end
    end
  end

  initial begin : stimulus
    plan_row_t p;
    int ph;
    int n;
    int k;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    req_type = '0;
    virt_addr = '0;
    phys_addr = '0;
    page_flags = '0;
    range_end = '0;
    foreach (mirror_entry[i])
      mirror_entry[i] = '0;
    mirror_next_table = 1;
    mirror_base = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part
    for (k = 0; k < PLAN_ROWS; k++) begin
      p = plan_row(k);
      if (p.cfg) begin
        set_pool_base(p.base);
      end else begin
        offer(p.rq, p.fixed, p.want);
        sender_gap(idle_len());
      end
    end

    // Random part: pool at 0, at the top (aliased), at a random base, back at 0
    for (ph = 0; ph < 4; ph++) begin
      if (ph == 1)
        set_pool_base(BASE_TOP);
      else if (ph == 2)
        set_pool_base({20'($urandom_range(0, 20'hFFFFE)), 32'($urandom)});
      else if (ph == 3)
        set_pool_base('0);
      n = (ph == 0) ? 400 : (ph == 3) ? 300 : 150;
      for (k = 0; k < n; k++) begin
        offer(random_req((ph == 3) ? 15 : 2), 1'b0, '0);
        sender_gap(((k / 40) % 3 == 0) ? 0 : idle_len());
      end
    end

    // Drain and let the walker settle
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);

    $display("%0d requests over %0d pool_base settings: %0d ok, %0d not mapped or skipped,",
             requests_sent, base_writes, status_seen[ST_OK], status_seen[ST_NONE]);
    $display("  %0d huge, %0d pool full, %0d bad address, %0d flushes, %0d tables in use",
             status_seen[ST_HUGE], status_seen[ST_FULL], status_seen[ST_BAD], flush_seen,
             mirror_next_table);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("timeout with %0d results outstanding", due_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
